[sv/rsi_pkg.sv]
// Shared constants and helpers for the 2D ray versus segment intersection block.
// No dependencies; rsi_cfg_if, rsi_div, the top level and tb_top use it.
package rsi_pkg;

    localparam int IDX_WIDTH = 8;
    localparam logic [IDX_WIDTH-1:0] REG_PARALLEL_TOL = 8'd0;
    localparam logic [IDX_WIDTH-1:0] REG_LOOSE_TOL    = 8'd1;

    localparam logic [31:0] PARALLEL_TOL_RST = 32'd4295;
    localparam logic [15:0] LOOSE_TOL_RST    = 16'd7;

    // Quotient bits kept by the divider; magnitudes above QUOT_CLAMP clamp to it.
    localparam int QBITS = 42;
    localparam logic [QBITS-2:0] QUOT_CLAMP = {1'b1, {(QBITS-2){1'b0}}};
    localparam int FRAC_BITS = 16;
    localparam logic signed [QBITS-1:0] Q_ONE = 42'sd65536;

    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        logic signed [31:0] res;
        if (v > 72'sd2147483647) begin
            res = 32'sh7fff_ffff;
        end else if (v < -72'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

[sv/rsi_in_if.sv]
// Query channel of the intersection block: valid/ready plus one ray and one segment.
// Depends on nothing.
interface rsi_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] origin_x;
    logic [31:0] origin_y;
    logic [31:0] direction_x;
    logic [31:0] direction_y;
    logic [31:0] seg_start_x;
    logic [31:0] seg_start_y;
    logic [31:0] seg_end_x;
    logic [31:0] seg_end_y;
    logic        both_ways;
    modport source (output valid, origin_x, origin_y, direction_x, direction_y,
                    seg_start_x, seg_start_y, seg_end_x, seg_end_y, both_ways,
                    input ready);
    modport sink   (input valid, origin_x, origin_y, direction_x, direction_y,
                    seg_start_x, seg_start_y, seg_end_x, seg_end_y, both_ways,
                    output ready);
endinterface

[sv/rsi_out_if.sv]
// Result channel of the intersection block: valid/ready plus hit, parameters and point.
// Depends on nothing.
interface rsi_out_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [31:0] ray_param;
    logic [31:0] seg_param;
    logic [31:0] point_x;
    logic [31:0] point_y;
    modport source (output valid, hit, ray_param, seg_param, point_x, point_y,
                    input ready);
    modport sink   (input valid, hit, ray_param, seg_param, point_x, point_y,
                    output ready);
endinterface

[sv/rsi_cfg_if.sv]
// Register write channel of the intersection block: valid/ready, index and data.
// Depends on rsi_pkg for the index width.
interface rsi_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rsi_pkg::IDX_WIDTH-1:0]  index;
    logic [31:0]                    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[sv/rsi_div.sv]
// Pipelined restoring divider: quotient of (num * 2^16) / den, one bit per stage,
// clamped to QUOT_CLAMP. Stages advance only while i_en is high. Depends on rsi_pkg.
module rsi_div #(
    parameter int MW = 67
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [MW-1:0]                 i_num,
    input  logic [MW-1:0]                 i_den,
    output logic [rsi_pkg::QBITS-2:0]     o_quot
);
    localparam int QB = rsi_pkg::QBITS;
    localparam int RW = MW + QB;

    logic [RW-1:0] r_rem [QB+1];
    logic [MW-1:0] r_den [QB+1];
    logic [QB-1:0] r_q   [QB+1];
    logic          r_ovf [QB+1];

    logic [RW-1:0] n_rem0;
    assign n_rem0 = RW'(i_num) << rsi_pkg::FRAC_BITS;

    // The first stage flags quotients that do not fit in QB bits; they clamp anyway.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_rem0;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_ovf[0] <= n_rem0 >= (RW'(i_den) << QB);
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_step
        logic [RW-1:0] trial;
        logic          take;
        assign trial = RW'(r_den[k-1]) << (QB - k);
        assign take  = r_rem[k-1] >= trial;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= take ? r_rem[k-1] - trial : r_rem[k-1];
                r_den[k] <= r_den[k-1];
                r_q[k]   <= r_q[k-1] | (take ? (QB'(1) << (QB - k)) : '0);
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_quot = (r_ovf[QB] || r_q[QB] > QB'(rsi_pkg::QUOT_CLAMP)) ?
                    rsi_pkg::QUOT_CLAMP : r_q[QB][QB-2:0];

endmodule

[sv/ray_segment_intersect_2d.sv]
// Top level of the 2D ray versus line-segment intersection pipeline.
// Depends on rsi_pkg, the three channel interfaces and rsi_div.
//
// Usage: queries enter on i_in (ray origin, direction, segment ends, both_ways),
// one per cycle while i_in.ready is high. Each query yields exactly one result on
// o_out: hit, ray parameter s, segment parameter t and the hit point, all Q16.16;
// a miss returns all fields zero. Registers are written on i_cfg (index 0 parallel
// tolerance, index 1 loose tolerance), always ready; the user must write them only
// while no query is in flight, which the block does not enforce. Coordinates are read
// from their low COORD_WIDTH bits. Pipeline: 50 register stages (4 of differences,
// products, cross products and magnitudes, 43 divider stages, 3 output stages).
// Throughput: one query per cycle, set by the one-bit-per-stage divider pipelines.
// The whole pipeline advances together; when the receiver holds o_out.ready low
// with a result waiting, every stage freezes and i_in.ready drops, so nothing is
// lost or repeated. Reset empties the pipeline and restores the register defaults.
module ray_segment_intersect_2d #(
    parameter int COORD_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rsi_in_if.sink      i_in,
    rsi_cfg_if.sink     i_cfg,
    rsi_out_if.source   o_out
);
    localparam int W   = COORD_WIDTH;
    localparam int DW  = W + 1;
    localparam int PRW = 2 * DW;
    localparam int PW  = PRW + 1;
    localparam int QB  = rsi_pkg::QBITS;
    localparam int MPW = W + 32;
    localparam int DLY = QB + 1;

    typedef struct packed {
        logic signed [W-1:0] ox;
        logic signed [W-1:0] oy;
        logic signed [W-1:0] dx;
        logic signed [W-1:0] dy;
        logic                both;
    } t_pass;

    typedef struct packed {
        t_pass pass;
        logic  par;
        logic  neg_s;
        logic  neg_t;
    } t_side;

    logic [31:0] r_par_tol;
    logic [15:0] r_loose_tol;
    logic        en;

    // Register writes.
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_par_tol   <= rsi_pkg::PARALLEL_TOL_RST;
            r_loose_tol <= rsi_pkg::LOOSE_TOL_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                rsi_pkg::REG_PARALLEL_TOL: r_par_tol   <= i_cfg.data;
                rsi_pkg::REG_LOOSE_TOL:    r_loose_tol <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    logic r_ovld;
    assign en         = !r_ovld || o_out.ready;
    assign i_in.ready = en;

    // Stage 1: differences.
    logic               r1_vld;
    t_pass              r1_pass;
    logic signed [DW-1:0] r1_dx, r1_dy, r1_gx, r1_gy, r1_wx, r1_wy;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_pass.ox   <= $signed(i_in.origin_x[W-1:0]);
            r1_pass.oy   <= $signed(i_in.origin_y[W-1:0]);
            r1_pass.dx   <= $signed(i_in.direction_x[W-1:0]);
            r1_pass.dy   <= $signed(i_in.direction_y[W-1:0]);
            r1_pass.both <= i_in.both_ways;
            r1_dx <= DW'($signed(i_in.direction_x[W-1:0]));
            r1_dy <= DW'($signed(i_in.direction_y[W-1:0]));
            r1_gx <= DW'($signed(i_in.seg_end_x[W-1:0])) - DW'($signed(i_in.seg_start_x[W-1:0]));
            r1_gy <= DW'($signed(i_in.seg_end_y[W-1:0])) - DW'($signed(i_in.seg_start_y[W-1:0]));
            r1_wx <= DW'($signed(i_in.seg_start_x[W-1:0])) - DW'($signed(i_in.origin_x[W-1:0]));
            r1_wy <= DW'($signed(i_in.seg_start_y[W-1:0])) - DW'($signed(i_in.origin_y[W-1:0]));
        end
    end

    // Stage 2: the six products of the three cross products.
    t_pass                 r2_pass;
    logic signed [PRW-1:0] r2_dgy, r2_dygx, r2_wgy, r2_wygx, r2_wdy, r2_wydx;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_pass <= r1_pass;
            r2_dgy  <= PRW'(r1_dx) * PRW'(r1_gy);
            r2_dygx <= PRW'(r1_dy) * PRW'(r1_gx);
            r2_wgy  <= PRW'(r1_wx) * PRW'(r1_gy);
            r2_wygx <= PRW'(r1_wy) * PRW'(r1_gx);
            r2_wdy  <= PRW'(r1_wx) * PRW'(r1_dy);
            r2_wydx <= PRW'(r1_wy) * PRW'(r1_dx);
        end
    end

    // Stage 3: cross products.
    t_pass                r3_pass;
    logic signed [PW-1:0] r3_den, r3_ns, r3_nt;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_pass <= r2_pass;
            r3_den  <= PW'(r2_dgy) - PW'(r2_dygx);
            r3_ns   <= PW'(r2_wgy) - PW'(r2_wygx);
            r3_nt   <= PW'(r2_wdy) - PW'(r2_wydx);
        end
    end

    // Stage 4: magnitudes, signs and the parallel test.
    t_side         r4_side;
    logic [PW-1:0] r4_aden, r4_ans, r4_ant;
    logic [PW-1:0] n_aden;
    assign n_aden = r3_den[PW-1] ? PW'(-r3_den) : PW'(r3_den);
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_side.pass  <= r3_pass;
            r4_side.par   <= (n_aden == '0) || (n_aden < PW'(r_par_tol));
            r4_side.neg_s <= r3_ns[PW-1] ^ r3_den[PW-1];
            r4_side.neg_t <= r3_nt[PW-1] ^ r3_den[PW-1];
            r4_aden       <= n_aden;
            r4_ans        <= r3_ns[PW-1] ? PW'(-r3_ns) : PW'(r3_ns);
            r4_ant        <= r3_nt[PW-1] ? PW'(-r3_nt) : PW'(r3_nt);
        end
    end

    // Divider stages; the side data follows in a matching delay line.
    logic [QB-2:0] qs, qt;
    rsi_div #(.MW(PW)) u_div_s (.i_clk(i_clk), .i_en(en), .i_num(r4_ans), .i_den(r4_aden),
                                .o_quot(qs));
    rsi_div #(.MW(PW)) u_div_t (.i_clk(i_clk), .i_en(en), .i_num(r4_ant), .i_den(r4_aden),
                                .o_quot(qt));

    t_side r_side [DLY];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= r4_side;
            for (int k = 1; k < DLY; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // Post stage: signs, bound tests and saturation.
    logic signed [QB-1:0] sq, tq, loose;
    logic                 n_hit;
    assign sq    = r_side[DLY-1].neg_s ? -$signed(QB'(qs)) : $signed(QB'(qs));
    assign tq    = r_side[DLY-1].neg_t ? -$signed(QB'(qt)) : $signed(QB'(qt));
    assign loose = $signed(QB'(r_loose_tol));
    assign n_hit = !r_side[DLY-1].par && !(tq < -loose) && !(tq > rsi_pkg::Q_ONE + loose)
                   && (r_side[DLY-1].pass.both || !(sq < -loose));

    logic               r5_hit;
    logic signed [31:0] r5_s, r5_t;
    t_pass              r5_pass;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_hit  <= n_hit;
            r5_s    <= n_hit ? rsi_pkg::sat32(72'(sq)) : '0;
            r5_t    <= n_hit ? rsi_pkg::sat32(72'(tq)) : '0;
            r5_pass <= r_side[DLY-1].pass;
        end
    end

    // Multiply stage: direction times s.
    logic                 r6_hit;
    logic signed [31:0]   r6_s, r6_t;
    logic signed [W-1:0]  r6_ox, r6_oy;
    logic signed [MPW-1:0] r6_mx, r6_my;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_hit <= r5_hit;
            r6_s   <= r5_s;
            r6_t   <= r5_t;
            r6_ox  <= r5_pass.ox;
            r6_oy  <= r5_pass.oy;
            r6_mx  <= MPW'(r5_pass.dx) * MPW'(r5_s);
            r6_my  <= MPW'(r5_pass.dy) * MPW'(r5_s);
        end
    end

    // Output stage: floor shift, add origin, saturate.
    logic signed [MPW:0] px, py;
    assign px = (MPW+1)'(r6_mx >>> rsi_pkg::FRAC_BITS) + (MPW+1)'(r6_ox);
    assign py = (MPW+1)'(r6_my >>> rsi_pkg::FRAC_BITS) + (MPW+1)'(r6_oy);

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_out.hit       <= r6_hit;
            o_out.ray_param <= r6_s;
            o_out.seg_param <= r6_t;
            o_out.point_x   <= r6_hit ? rsi_pkg::sat32(72'(px)) : '0;
            o_out.point_y   <= r6_hit ? rsi_pkg::sat32(72'(py)) : '0;
        end
    end

    // Valid bits, one per stage.
    localparam int NST = 4 + DLY + 2;
    logic [NST-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else if (en) begin
            r_vld  <= {r_vld[NST-2:0], i_in.valid};
            r_ovld <= r_vld[NST-1];
        end
    end
    assign r1_vld      = r_vld[0];
    assign o_out.valid = r_ovld;

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.hit) |-> (o_out.ray_param == '0 && o_out.seg_param == '0
            && o_out.point_x == '0 && o_out.point_y == '0))
        else $error("miss result carries nonzero fields");
    a_hit_t_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.hit) |->
            ($signed(o_out.seg_param) >= -$signed({16'd0, r_loose_tol})
            && $signed(o_out.seg_param) <= $signed(32'd65536 + {16'd0, r_loose_tol})))
        else $error("hit with segment parameter out of bounds");
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> ($stable(r_vld) && $stable(o_out.ray_param)))
        else $error("pipeline moved during a stall");
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready == (!o_out.valid || o_out.ready))
        else $error("input ready does not follow the output stall");
    a_first_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r1_vld) |=> r_vld[1])
        else $error("valid bit lost between stages");

endmodule

[dv/rsi_tb_if.sv]
`timescale 1ns / 100ps
// Testbench-side notes for the intersection block's channels.
// The channel interfaces come from the RTL (rsi_in_if, rsi_out_if, rsi_cfg_if); this file adds none.
package rsi_tb_pkg;
    localparam int LATENCY = 49;
endpackage

[dv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for ray_segment_intersect_2d: directed table, then random queries,
// each checked against a given answer or an in-bench predictor. Depends on rsi_pkg, the RTL.
module tb_top;

    typedef struct packed {
        logic [31:0] ox, oy, dx, dy, sx, sy, ex, ey;
        logic        both;
    } t_query;

    typedef struct packed {
        logic        hit;
        logic [31:0] s, t, px, py;
    } t_answer;

    typedef struct {
        t_query  q;
        logic    known;
        t_answer a;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rsi_in_if  in_ch();
    rsi_out_if out_ch();
    rsi_cfg_if cfg_ch();

    ray_segment_intersect_2d dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .i_cfg(cfg_ch), .o_out(out_ch)
    );

    // First index past the register list.
    localparam logic [rsi_pkg::IDX_WIDTH-1:0] REG_BEYOND = rsi_pkg::REG_LOOSE_TOL + 1'b1;

    logic [31:0] par_tol;
    logic [15:0] loose_tol;
    t_answer     expected_answers[$];
    int          errors = 0;
    int          src_idle_pct = 0;
    int          rcv_stall_pct = 0;
    int          hold_cycles = 0;
    int          results_seen = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic logic signed [127:0] div_trunc(input logic signed [127:0] num,
                                                      input logic signed [127:0] den);
        logic [127:0] n, d, q;
        logic         neg;
        neg = num[127] ^ den[127];
        n = num[127] ? -num : num;
        d = den[127] ? -den : den;
        q = (n << 16) / d;
        if (q > (128'd1 << 40)) q = 128'd1 << 40;
        return neg ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [63:0] clamp32(input logic signed [127:0] v);
        if (v > 128'sd2147483647) return 64'sd2147483647;
        if (v < -128'sd2147483648) return -64'sd2147483648;
        return v[63:0];
    endfunction

    function automatic t_answer predict_intersection(input t_query q);
        logic signed [127:0] ox, oy, dx, dy, gx, gy, wx, wy, den, aden, s, t, lo;
        logic signed [127:0] px, py;
        t_answer r;
        ox = $signed(q.ox); oy = $signed(q.oy);
        dx = $signed(q.dx); dy = $signed(q.dy);
        gx = $signed(q.ex) - $signed(q.sx); gy = $signed(q.ey) - $signed(q.sy);
        wx = $signed(q.sx) - ox;            wy = $signed(q.sy) - oy;
        lo = $signed({112'd0, loose_tol});
        r = '0;
        den = dx * gy - dy * gx;
        aden = den[127] ? -den : den;
        if (aden == 0 || aden < $signed({96'd0, par_tol})) return r;
        s = div_trunc(wx * gy - wy * gx, den);
        t = div_trunc(wx * dy - wy * dx, den);
        if (t < -lo || t > 128'sd65536 + lo) return r;
        if (!q.both && s < -lo) return r;
        s = clamp32(s);
        t = clamp32(t);
        // Arithmetic shift floors, matching the round-toward-minus-infinity rule.
        px = clamp32(ox + ((dx * s) >>> 16));
        py = clamp32(oy + ((dy * s) >>> 16));
        r.hit = 1'b1;
        r.s = s[31:0]; r.t = t[31:0]; r.px = px[31:0]; r.py = py[31:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s at result %0d: got %h expected %h",
                 what, results_seen, got, want);
        errors++;
    endtask

    // Result side: stall by percentage or for a counted hold, check every transfer.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_answer w;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_answers.size() == 0) begin
                report_mismatch("unexpected result transfer", 32'd1, 32'd0);
            end else begin
                w = expected_answers.pop_front();
                if (out_ch.hit !== w.hit)       report_mismatch("hit", out_ch.hit, w.hit);
                if (out_ch.ray_param !== w.s)   report_mismatch("ray_param", out_ch.ray_param, w.s);
                if (out_ch.seg_param !== w.t)   report_mismatch("seg_param", out_ch.seg_param, w.t);
                if (out_ch.point_x !== w.px)    report_mismatch("point_x", out_ch.point_x, w.px);
                if (out_ch.point_y !== w.py)    report_mismatch("point_y", out_ch.point_y, w.py);
            end
            results_seen++;
        end
    end

    task automatic write_reg(input logic [rsi_pkg::IDX_WIDTH-1:0] idx, input logic [31:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == rsi_pkg::REG_PARALLEL_TOL) par_tol = val;
        else if (idx == rsi_pkg::REG_LOOSE_TOL) loose_tol = val[15:0];
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Sender: optional idle cycles, then one transfer. Called at a falling edge; it leaves
    // valid high, and a caller that pauses lowers it first.
    task automatic send_query(input t_query q, input logic known, input t_answer a);
        t_answer p;
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        {in_ch.origin_x, in_ch.origin_y, in_ch.direction_x, in_ch.direction_y,
         in_ch.seg_start_x, in_ch.seg_start_y, in_ch.seg_end_x, in_ch.seg_end_y,
         in_ch.both_ways} <= q;
        in_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        p = predict_intersection(q);
        expected_answers.push_back(known ? a : p);
        @(negedge i_clk);
    endtask

    task automatic drain();
        int guard;
        in_ch.valid <= 1'b0;
        guard = 0;
        while (expected_answers.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (rsi_tb_pkg::LATENCY + 10) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord(input int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
            2: return ($urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000) ^ $urandom_range(3);
            default: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        endcase
    endfunction

    // Builds a query that mostly yields a hit: the segment straddles a point on the ray.
    function automatic t_query rand_query();
        t_query q;
        int m;
        logic signed [31:0] ps;
        logic signed [63:0] hx, hy;
        m = $urandom_range(9);
        if (m < 6) begin
            q.ox = rand_coord(3); q.oy = rand_coord(3);
            q.dx = rand_coord(3); q.dy = rand_coord(3);
            ps = $signed($urandom_range(0, 32'h0003_0000)) - 32'sh0000_8000;
            hx = (64'($signed(q.dx)) * 64'(ps)) >>> 16;
            hy = (64'($signed(q.dy)) * 64'(ps)) >>> 16;
            q.sx = q.ox + hx[31:0] + rand_coord(3);
            q.sy = q.oy + hy[31:0] + rand_coord(3);
            q.ex = ((q.ox + hx[31:0]) << 1) - q.sx + rand_coord(1);
            q.ey = ((q.oy + hy[31:0]) << 1) - q.sy + rand_coord(1);
        end else begin
            m = $urandom_range(3);
            q.ox = rand_coord(m); q.oy = rand_coord(m); q.dx = rand_coord(m);
            q.dy = rand_coord(m); q.sx = rand_coord(m); q.sy = rand_coord(m);
            q.ex = rand_coord(m); q.ey = rand_coord(m);
        end
        if ($urandom_range(19) == 0) q.dy = q.dx;
        q.both = 1'($urandom_range(1));
        return q;
    endfunction

    localparam logic [31:0] MAXP = 32'h7FFF_FFFF;
    localparam logic [31:0] MINN = 32'h8000_0000;
    localparam logic [31:0] ONE  = 32'h0001_0000;

    t_row directed[$];

    task automatic add_row(input t_query q, input logic known, input t_answer a);
        t_row r;
        r.q = q; r.known = known; r.a = a;
        directed.push_back(r);
    endtask

    initial begin
        t_answer miss;
        t_answer cross_hit;
        logic [31:0] par_set[4];
        logic [31:0] loose_set[4];
        miss = '0;
        // Ray along +x from the origin meets the vertical segment x=1, y in [-1,1] at s=1, t=1/2.
        cross_hit = '{1'b1, ONE, 32'h0000_8000, ONE, 32'h0};
        in_ch.valid = 1'b0;
        {in_ch.origin_x, in_ch.origin_y, in_ch.direction_x, in_ch.direction_y,
         in_ch.seg_start_x, in_ch.seg_start_y, in_ch.seg_end_x, in_ch.seg_end_y,
         in_ch.both_ways} = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        par_tol = rsi_pkg::PARALLEL_TOL_RST;
        loose_tol = rsi_pkg::LOOSE_TOL_RST;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        add_row('{32'h0, 32'h0, ONE, 32'h0, ONE, 32'hFFFF_0000, ONE, ONE, 1'b0}, 1'b1, cross_hit);
        // Same segment behind the ray: forward-only misses, both ways hits.
        add_row('{32'h0, 32'h0, 32'hFFFF_0000, 32'h0, ONE, 32'hFFFF_0000, ONE, ONE, 1'b0},
                1'b1, miss);
        add_row('{32'h0, 32'h0, 32'hFFFF_0000, 32'h0, ONE, 32'hFFFF_0000, ONE, ONE, 1'b1},
                1'b0, miss);
        // Zero cross product: parallel and degenerate.
        add_row('{32'h0, 32'h0, ONE, 32'h0, 32'h0, ONE, ONE, ONE, 1'b1}, 1'b1, miss);
        add_row('{32'h0, 32'h0, 32'h0, 32'h0, ONE, ONE, MAXP, MINN, 1'b1}, 1'b1, miss);
        add_row('{32'h0, 32'h0, ONE, ONE, ONE, ONE, ONE, ONE, 1'b1}, 1'b1, miss);
        // Tiny cross product below the parallel bound.
        add_row('{32'h0, 32'h0, 32'h1, 32'h0, 32'h5, 32'h0, 32'h5, 32'h100, 1'b1}, 1'b1, miss);
        // Segment ends exactly on the ray: t at 0 and 1.
        add_row('{32'h0, 32'h0, ONE, 32'h0, ONE, 32'h0, ONE, ONE, 1'b0}, 1'b0, miss);
        add_row('{32'h0, 32'h0, ONE, 32'h0, ONE, 32'hFFFF_0000, ONE, 32'h0, 1'b0}, 1'b0, miss);
        // Extreme coordinates, where quotients clamp and the point saturates.
        add_row('{MAXP, MAXP, MAXP, 32'h1, MINN, MINN, MAXP, MAXP, 1'b1}, 1'b0, miss);
        add_row('{MINN, MINN, MINN, MAXP, MAXP, MINN, MINN, MAXP, 1'b1}, 1'b0, miss);
        add_row('{MAXP, MINN, 32'h1, 32'hFFFF_FFFF, MINN, MAXP, MAXP, MINN, 1'b0}, 1'b0, miss);
        add_row('{32'h0, 32'h0, 32'h1, 32'h0, MAXP, MINN, MAXP, MAXP, 1'b1}, 1'b0, miss);
        add_row('{MINN, 32'h0, MAXP, 32'h0, 32'h0, MINN, 32'h0, MAXP, 1'b0}, 1'b0, miss);
        add_row('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0,
                  32'hFFFF_FFFF, 1'b1}, 1'b0, miss);

        foreach (directed[i]) send_query(directed[i].q, directed[i].known, directed[i].a);
        drain();

        par_set   = '{32'h0, 32'hFFFF_FFFF, 32'd1, rsi_pkg::PARALLEL_TOL_RST};
        loose_set = '{16'h0, 16'hFFFF, 16'd300, rsi_pkg::LOOSE_TOL_RST};
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(rsi_pkg::REG_PARALLEL_TOL, par_set[ph % 4]);
            write_reg(rsi_pkg::REG_LOOSE_TOL, loose_set[(ph + 1) % 4]);
            // Index beyond the register list must be ignored.
            if (ph == 2) write_reg(REG_BEYOND, 32'h1234_5678);
            case (ph % 4)
                0: begin src_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin src_idle_pct = 85; rcv_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  rcv_stall_pct = 85; end
                default: begin src_idle_pct = 14; rcv_stall_pct = 14; end
            endcase
            if (ph == 4) hold_cycles = 300;
            for (int n = 0; n < 190; n++) begin
                send_query(rand_query(), 1'b0, miss);
                // The sender pauses mid-phase until every result is back.
                if (ph == 5 && n == 90) drain();
            end
            drain();
        end

        if (errors == 0 && expected_answers.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

[ray_segment_intersect_2d.f]
sv/rsi_pkg.sv
sv/rsi_in_if.sv
sv/rsi_out_if.sv
sv/rsi_cfg_if.sv
sv/rsi_div.sv
sv/ray_segment_intersect_2d.sv
dv/rsi_tb_if.sv
dv/tb_top.sv
